### hw/rtl/ledsr_pkg.sv
// Shared types and constants for the serial LED driver refresh block.
`default_nettype none

package ledsr_pkg;

  localparam int unsigned DigitCount = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned SlotCntW   = 6;
  localparam int unsigned PaddrW     = 3;

  localparam logic [ByteW-1:0] DisplayModeRst = 8'h88;
  localparam logic [ByteW-1:0] DataModeRst    = 8'h40;
  localparam logic [ByteW-1:0] BrightOffCmd   = 8'h80;
  localparam logic [ByteW-1:0] BrightBaseCmd  = 8'h88;
  localparam logic [3:0]       BrightMax      = 4'd8;
  localparam logic [3:0]       AddrCmdHigh    = 4'hC;

  // last slot position of each sequence kind, then frame length, address gap slot and data-byte shift
  localparam logic [SlotCntW-1:0] CmdOneLast   = 6'd20;
  localparam logic [SlotCntW-1:0] CmdTwoLast   = 6'd41;
  localparam logic [SlotCntW-1:0] AddrDataLast = 6'd37;
  localparam logic [SlotCntW-1:0] FrameLen     = 6'd21;
  localparam logic [SlotCntW-1:0] AddrGapPos   = 6'd18;
  localparam logic [SlotCntW-1:0] DataShift    = 6'd17;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_BRIGHT  = 2'd1,
    ACT_REFRESH = 2'd2,
    ACT_WRITE   = 2'd3
  } action_e;

  typedef enum logic {
    REG_DISPLAY_MODE = 1'b0,
    REG_DATA_MODE    = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    SEQ_CMD_ONE,
    SEQ_CMD_TWO,
    SEQ_ADDR_DATA
  } seq_e;

  typedef struct packed {
    seq_e             kind;
    logic [ByteW-1:0] byte_a;
    logic [ByteW-1:0] byte_b;
  } seq_cmd_t;

  typedef struct packed {
    logic clk_lvl;
    logic dio_lvl;
    logic last;
  } slot_t;

endpackage

`default_nettype wire

### hw/rtl/ledsr_slot_gen.sv
// Slot sequencer: walks one frame sequence and decodes the pin levels of each slot.
`default_nettype none

module ledsr_slot_gen (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  ledsr_pkg::seq_cmd_t cmd_i,
  input  wire                 adv_i,
  output logic                busy_o,
  output ledsr_pkg::slot_t    slot_o
);

  logic                               busy_q, busy_d;
  logic [ledsr_pkg::SlotCntW-1:0]     cnt_q, cnt_d;
  ledsr_pkg::seq_cmd_t                cmd_q, cmd_d;
  logic [ledsr_pkg::SlotCntW-1:0]     pos_b;
  logic [ledsr_pkg::SlotCntW-1:0]     pos_d;
  logic [1:0]                         lvl;

  // {clock, data} for position p of a single-byte command frame
  function automatic logic [1:0] cmd_slot(input logic [4:0] p,
                                          input logic [ledsr_pkg::ByteW-1:0] b);
    logic [4:0] q;
    logic [1:0] r;
    begin
      q = p - 5'd2;
      if (p == 5'd0) begin
        r = 2'b11;
      end else if (p == 5'd1) begin
        r = 2'b10;
      end else if (p < 5'd18) begin
        r = {q[0], b[q[3:1]]};
      end else if (p == 5'd18) begin
        r = 2'b00;
      end else if (p == 5'd19) begin
        r = 2'b10;
      end else begin
        r = 2'b11;
      end
      cmd_slot = r;
    end
  endfunction

  assign pos_b = cnt_q - ledsr_pkg::FrameLen;
  assign pos_d = cnt_q - ledsr_pkg::DataShift;

  always_comb begin
    lvl         = 2'b11;
    slot_o.last = 1'b0;
    case (cmd_q.kind)
      ledsr_pkg::SEQ_CMD_ONE: begin
        lvl         = cmd_slot(cnt_q[4:0], cmd_q.byte_a);
        slot_o.last = (cnt_q == ledsr_pkg::CmdOneLast);
      end
      ledsr_pkg::SEQ_CMD_TWO: begin
        if (cnt_q < ledsr_pkg::FrameLen) begin
          lvl = cmd_slot(cnt_q[4:0], cmd_q.byte_a);
        end else begin
          lvl = cmd_slot(pos_b[4:0], cmd_q.byte_b);
        end
        slot_o.last = (cnt_q == ledsr_pkg::CmdTwoLast);
      end
      ledsr_pkg::SEQ_ADDR_DATA: begin
        // address byte, one gap slot, then data byte and stop
        if (cnt_q < ledsr_pkg::AddrGapPos) begin
          lvl = cmd_slot(cnt_q[4:0], cmd_q.byte_a);
        end else if (cnt_q == ledsr_pkg::AddrGapPos) begin
          lvl = {1'b0, cmd_q.byte_a[ledsr_pkg::ByteW-1]};
        end else begin
          lvl = cmd_slot(pos_d[4:0], cmd_q.byte_b);
        end
        slot_o.last = (cnt_q == ledsr_pkg::AddrDataLast);
      end
      default: begin
        lvl         = 2'b11;
        slot_o.last = 1'b1;
      end
    endcase
    slot_o.clk_lvl = lvl[1];
    slot_o.dio_lvl = lvl[0];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    cmd_d  = cmd_q;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      cmd_d  = cmd_i;
    end else if (adv_i) begin
      cnt_d = cnt_q + 6'd1;
      if (slot_o.last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

### hw/rtl/led_driver_serial_refresh.sv
// Top level: action intake, frame store, digit index, command registers, slot output.
//
// Usage: each item on the s_axis channel is one action for a two-wire LED
// driver chip. Init, brightness and refresh actions each produce a run of
// pin slots on the m_axis channel, one slot per transfer, with tlast on the
// final slot of the run. A write action stores one byte of the 16-entry
// frame store and produces no slot.
// Slot counts: init 42, brightness 21, refresh 38. The slot sequencer emits
// one slot per cycle while the receiver does not stall; runs follow each
// other back to back when the next action waits in the intake register.
// The first slot of a run passes the intake register, the sequencer state
// register and then the output register before it shows on m_axis.
// A one-entry intake register takes the next action while the current run
// is still being emitted. When the receiver stalls, the output register
// holds its slot and the sequencer and intake stop behind it; writes still retire.
// Reset clears the digit index and the frame store and loads the command
// registers with their defaults; no transfer is pending after reset.
// The APB port writes the two init command bytes; write them only while idle.
`default_nettype none

module led_driver_serial_refresh (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // s_axis_tdata: [1:0] action, [5:2] level, [9:6] entry_index,
  // [17:10] entry_value, [23:18] zero
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [23:0]                  s_axis_tdata,
  // m_axis_tdata: [0] clock_level, [1] data_level, [7:2] zero
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [7:0]                   m_axis_tdata,
  output logic                         m_axis_tlast,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [ledsr_pkg::PaddrW-1:0] paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned ByteW = ledsr_pkg::ByteW;
  localparam int unsigned IdxW  = ledsr_pkg::IdxW;

  // configuration
  logic [ByteW-1:0] disp_cmd_q, data_cmd_q;
  logic             cfg_wr;
  ledsr_pkg::reg_e  cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = ledsr_pkg::reg_e'(paddr[2]);

  always_comb begin
    unique case (cfg_reg)
      ledsr_pkg::REG_DISPLAY_MODE: prdata = {24'd0, disp_cmd_q};
      ledsr_pkg::REG_DATA_MODE:    prdata = {24'd0, data_cmd_q};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_cmd_q <= ledsr_pkg::DisplayModeRst;
      data_cmd_q <= ledsr_pkg::DataModeRst;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        ledsr_pkg::REG_DISPLAY_MODE: disp_cmd_q <= pwdata[ByteW-1:0];
        ledsr_pkg::REG_DATA_MODE:    data_cmd_q <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // intake register
  logic                buf_valid_q;
  ledsr_pkg::action_e  buf_act_q;
  logic [3:0]          buf_level_q;
  logic [IdxW-1:0]     buf_idx_q;
  logic [ByteW-1:0]    buf_val_q;
  logic                buf_pop;
  logic                is_write;

  // sequencer handshake
  logic                gen_busy;
  logic                gen_adv;
  logic                gen_can_load;
  logic                gen_load;
  ledsr_pkg::seq_cmd_t gen_cmd;
  ledsr_pkg::slot_t    gen_slot;
  logic                out_free;

  assign is_write      = (buf_act_q == ledsr_pkg::ACT_WRITE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign gen_adv       = gen_busy && out_free;
  assign gen_can_load  = !gen_busy || (gen_adv && gen_slot.last);
  assign buf_pop       = buf_valid_q && (is_write || gen_can_load);
  assign gen_load      = buf_valid_q && !is_write && gen_can_load;
  assign s_axis_tready = !buf_valid_q || buf_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      buf_valid_q <= 1'b1;
    end else if (buf_pop) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      buf_act_q   <= ledsr_pkg::action_e'(s_axis_tdata[1:0]);
      buf_level_q <= s_axis_tdata[5:2];
      buf_idx_q   <= s_axis_tdata[9:6];
      buf_val_q   <= s_axis_tdata[17:10];
    end
  end

  // frame store and digit index
  logic [ByteW-1:0] store_q [ledsr_pkg::DigitCount];
  logic [IdxW-1:0]  digit_q;
  logic [IdxW:0]    digit_inc;
  logic [IdxW-1:0]  digit_next;

  assign digit_inc  = {1'b0, digit_q} + {{IdxW{1'b0}}, 1'b1};
  assign digit_next = (digit_inc >= (IdxW+1)'(ledsr_pkg::DigitCount)) ? '0
                                                                      : digit_inc[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ledsr_pkg::DigitCount; i++) begin
        store_q[i] <= '0;
      end
    end else if (buf_pop && is_write) begin
      store_q[buf_idx_q] <= buf_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (gen_load) begin
      case (buf_act_q)
        ledsr_pkg::ACT_INIT:    digit_q <= '0;
        ledsr_pkg::ACT_REFRESH: digit_q <= digit_next;
        default:                digit_q <= digit_q;
      endcase
    end
  end

  // sequence command for the action in the intake register
  logic [3:0]       lvl_sat;
  logic [3:0]       lvl_m1;
  logic [ByteW-1:0] bright_cmd;

  assign lvl_sat    = (buf_level_q > ledsr_pkg::BrightMax) ? ledsr_pkg::BrightMax : buf_level_q;
  assign lvl_m1     = lvl_sat - 4'd1;
  assign bright_cmd = (lvl_sat == 4'd0) ? ledsr_pkg::BrightOffCmd
                                        : ({4'd0, lvl_m1} | ledsr_pkg::BrightBaseCmd);

  always_comb begin
    gen_cmd.kind   = ledsr_pkg::SEQ_CMD_ONE;
    gen_cmd.byte_a = bright_cmd;
    gen_cmd.byte_b = '0;
    case (buf_act_q)
      ledsr_pkg::ACT_INIT: begin
        gen_cmd.kind   = ledsr_pkg::SEQ_CMD_TWO;
        gen_cmd.byte_a = disp_cmd_q;
        gen_cmd.byte_b = data_cmd_q;
      end
      ledsr_pkg::ACT_REFRESH: begin
        gen_cmd.kind   = ledsr_pkg::SEQ_ADDR_DATA;
        gen_cmd.byte_a = {ledsr_pkg::AddrCmdHigh, digit_q};
        gen_cmd.byte_b = store_q[digit_q];
      end
      default: begin
        gen_cmd.kind   = ledsr_pkg::SEQ_CMD_ONE;
        gen_cmd.byte_a = bright_cmd;
        gen_cmd.byte_b = '0;
      end
    endcase
  end

  ledsr_slot_gen u_slot_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (gen_load),
    .cmd_i  (gen_cmd),
    .adv_i  (gen_adv),
    .busy_o (gen_busy),
    .slot_o (gen_slot)
  );

  // output register
  logic out_valid_q;
  logic out_clk_q, out_dio_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (gen_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_adv) begin
      out_clk_q  <= gen_slot.clk_lvl;
      out_dio_q  <= gen_slot.dio_lvl;
      out_last_q <= gen_slot.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_dio_q, out_clk_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/ledsr_checker.sv
// Port-level checks on slot framing, pad bits, stall hold and pready, bound to the top level.
`default_nettype none

module ledsr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire        m_axis_tlast,
  input wire        pready
);

  logic after_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_last_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      after_last_q <= m_axis_tlast;
    end
  end

  // a run opens with the start slot: clock and data high
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && after_last_q |-> m_axis_tdata[1:0] == 2'b11)
    else $error("run does not open with start slot");

  // a run closes with the stop slot: clock and data high
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == 2'b11)
    else $error("run does not close with stop slot");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
    else $error("nonzero pad bits in slot transfer");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("slot changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && $past(pready))
    else $error("pready dropped");

endmodule

bind led_driver_serial_refresh ledsr_checker u_ledsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

`default_nettype wire

### tb/tb_led_driver_serial_refresh.sv
// Self-checking testbench for the serial LED driver refresh block: stream stimulus, slot checks.
`default_nettype none

module tb_led_driver_serial_refresh;

  localparam int unsigned IdxW       = ledsr_pkg::IdxW;
  localparam int unsigned ByteW      = ledsr_pkg::ByteW;
  localparam int unsigned DigitCount = ledsr_pkg::DigitCount;
  localparam int unsigned PaddrW     = ledsr_pkg::PaddrW;

  localparam int unsigned NumDirected   = 19;
  localparam int unsigned ItemsPerPhase = 60;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned IdlePause     = 4;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned StallLimit    = 3000;

  typedef struct packed {
    ledsr_pkg::action_e act;
    logic [3:0]         lvl;
    logic [IdxW-1:0]    idx;
    logic [ByteW-1:0]   val;
    logic               pinned;
    logic [ByteW-1:0]   byte_a;
    logic [ByteW-1:0]   byte_b;
  } step_t;

  // pinned rows carry the frame bytes expected on the pins
  localparam step_t DirectedSteps [NumDirected] = '{
    '{ledsr_pkg::ACT_INIT,    4'd0, 4'd0,  8'h00, 1'b1, 8'h88, 8'h40},
    '{ledsr_pkg::ACT_REFRESH, 4'd0, 4'd0,  8'h00, 1'b1, 8'hC0, 8'h00},
    '{ledsr_pkg::ACT_REFRESH, 4'hF, 4'hF,  8'hFF, 1'b1, 8'hC1, 8'h00},
    '{ledsr_pkg::ACT_BRIGHT,  4'd0, 4'd0,  8'h00, 1'b1, 8'h80, 8'h00},
    '{ledsr_pkg::ACT_BRIGHT,  4'd8, 4'd0,  8'h00, 1'b1, 8'h8F, 8'h00},
    '{ledsr_pkg::ACT_BRIGHT,  4'hF, 4'hF,  8'hFF, 1'b1, 8'h8F, 8'h00},
    '{ledsr_pkg::ACT_BRIGHT,  4'd9, 4'd0,  8'h00, 1'b1, 8'h8F, 8'h00},
    '{ledsr_pkg::ACT_BRIGHT,  4'd1, 4'd0,  8'h00, 1'b1, 8'h88, 8'h00},
    '{ledsr_pkg::ACT_BRIGHT,  4'd5, 4'd3,  8'h5A, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_WRITE,   4'd0, 4'd2,  8'hFF, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_WRITE,   4'hF, 4'd15, 8'hA5, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_WRITE,   4'd0, 4'd3,  8'h01, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_REFRESH, 4'd0, 4'd0,  8'h00, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_REFRESH, 4'd0, 4'd0,  8'h00, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_WRITE,   4'd0, 4'd0,  8'h80, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_INIT,    4'd3, 4'd9,  8'h77, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_REFRESH, 4'd0, 4'd0,  8'h00, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_WRITE,   4'd0, 4'd1,  8'h00, 1'b0, 8'h00, 8'h00},
    '{ledsr_pkg::ACT_REFRESH, 4'd7, 4'd6,  8'h3C, 1'b0, 8'h00, 8'h00}
  };

  localparam logic [ByteW-1:0] DisplaySettings [NumPhases] = '{8'h00, 8'hFF, 8'h00, 8'h88};
  localparam logic [ByteW-1:0] DataSettings    [NumPhases] = '{8'hFF, 8'h00, 8'h00, 8'h40};

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [1:0] action, [5:2] level, [9:6] entry_index, [17:10] entry_value, [23:18] zero
  logic [23:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [0] clock_level, [1] data_level, [7:2] zero
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow state of the block
  logic [ByteW-1:0]  display_cmd = ledsr_pkg::DisplayModeRst;
  logic [ByteW-1:0]  data_cmd = ledsr_pkg::DataModeRst;
  logic [IdxW-1:0]   next_digit = '0;
  logic [ByteW-1:0]  segment_bytes [DigitCount] = '{default: 8'h00};

  ledsr_pkg::slot_t  pending_slots [$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                long_hold_req = 1'b0;
  bit                sender_gaps = 1'b1;
  int unsigned       items_sent = 0;

  led_driver_serial_refresh u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  function automatic void queue_slot(logic clk_lvl, logic dio_lvl, logic last);
    ledsr_pkg::slot_t s;
    s.clk_lvl = clk_lvl;
    s.dio_lvl = dio_lvl;
    s.last    = last;
    pending_slots.push_back(s);
  endfunction

  // LSB first, data set in the low clock slot and held through the high one
  function automatic void queue_byte(logic [ByteW-1:0] b);
    for (int i = 0; i < ByteW; i++) begin
      queue_slot(1'b0, b[i], 1'b0);
      queue_slot(1'b1, b[i], 1'b0);
    end
  endfunction

  function automatic void queue_start();
    queue_slot(1'b1, 1'b1, 1'b0);
    queue_slot(1'b1, 1'b0, 1'b0);
  endfunction

  function automatic void queue_stop(logic last);
    queue_slot(1'b0, 1'b0, 1'b0);
    queue_slot(1'b1, 1'b0, 1'b0);
    queue_slot(1'b1, 1'b1, last);
  endfunction

  function automatic void queue_command(logic [ByteW-1:0] cmd, logic last);
    queue_start();
    queue_byte(cmd);
    queue_stop(last);
  endfunction

  // Update the shadow state for one action and queue the pin slots it causes.
  function automatic void expand_action(ledsr_pkg::action_e act, logic [3:0] lvl,
                                        logic [IdxW-1:0] idx, logic [ByteW-1:0] val,
                                        logic pinned,
                                        logic [ByteW-1:0] pin_a, logic [ByteW-1:0] pin_b);
    logic [ByteW-1:0] byte_a;
    logic [ByteW-1:0] byte_b;
    logic [3:0]       eff_lvl;
    byte_a = '0;
    byte_b = '0;
    case (act)
      ledsr_pkg::ACT_INIT: begin
        byte_a     = display_cmd;
        byte_b     = data_cmd;
        next_digit = '0;
      end
      ledsr_pkg::ACT_BRIGHT: begin
        eff_lvl = (lvl > ledsr_pkg::BrightMax) ? ledsr_pkg::BrightMax : lvl;
        byte_a  = (eff_lvl == 4'd0) ? ledsr_pkg::BrightOffCmd
                                    : (ledsr_pkg::BrightBaseCmd | ByteW'(eff_lvl - 4'd1));
      end
      ledsr_pkg::ACT_REFRESH: begin
        byte_a = {ledsr_pkg::AddrCmdHigh, next_digit};
        byte_b = segment_bytes[next_digit];
        next_digit = (next_digit == IdxW'(DigitCount - 1)) ? '0 : next_digit + 1'b1;
      end
      default: segment_bytes[idx] = val;
    endcase
    if (pinned) begin
      byte_a = pin_a;
      byte_b = pin_b;
    end
    case (act)
      ledsr_pkg::ACT_INIT: begin
        queue_command(byte_a, 1'b0);
        queue_command(byte_b, 1'b1);
      end
      ledsr_pkg::ACT_BRIGHT: queue_command(byte_a, 1'b1);
      ledsr_pkg::ACT_REFRESH: begin
        queue_start();
        queue_byte(byte_a);
        queue_slot(1'b0, byte_a[7], 1'b0);
        queue_byte(byte_b);
        queue_stop(1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic send_action(ledsr_pkg::action_e act, logic [3:0] lvl, logic [IdxW-1:0] idx,
                             logic [ByteW-1:0] val, logic pinned,
                             logic [ByteW-1:0] pin_a, logic [ByteW-1:0] pin_b);
    int unsigned pick;
    int unsigned gap;
    gap = 0;
    if (sender_gaps) begin
      pick = $urandom_range(0, 9);
      if (pick >= 9) gap = $urandom_range(8, 30);
      else if (pick >= 6) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {6'b0, val, idx, lvl, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    expand_action(act, lvl, idx, val, pinned, pin_a, pin_b);
    items_sent++;
  endtask

  task automatic send_random(ledsr_pkg::action_e act);
    logic [3:0] lvl;
    lvl = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
    send_action(act, lvl, 4'($urandom), 8'($urandom), 1'b0, 8'h00, 8'h00);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk_i);
    // a trailing write leaves no slot behind; let it retire
    repeat (IdlePause) @(posedge clk_i);
  endtask

  task automatic program_reg(ledsr_pkg::reg_e r, logic [ByteW-1:0] v);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({r, 2'b00});
    pwdata  <= {24'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == ledsr_pkg::REG_DISPLAY_MODE) display_cmd = v;
    else data_cmd = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (readback[ByteW-1:0] !== v) flag_mismatch("register readback", {24'b0, v}, readback);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned mode;
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end else if (mode < 9) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ledsr_pkg::slot_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_slots.size() == 0) begin
        flag_mismatch("unexpected slot clk/dio/last", 32'h0,
                      32'({m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast}));
      end else begin
        want = pending_slots.pop_front();
        if (m_axis_tdata[0] !== want.clk_lvl || m_axis_tdata[1] !== want.dio_lvl ||
            m_axis_tlast !== want.last) begin
          flag_mismatch("slot clk/dio/last", 32'(want),
                        32'({m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast}));
        end
      end
    end
  end

  // watchdog: count cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("led_driver_serial_refresh regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned phase_end;
    logic [ByteW-1:0] disp_v;
    logic [ByteW-1:0] data_v;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedSteps[i]) begin
      send_action(DirectedSteps[i].act, DirectedSteps[i].lvl, DirectedSteps[i].idx,
                  DirectedSteps[i].val, DirectedSteps[i].pinned,
                  DirectedSteps[i].byte_a, DirectedSteps[i].byte_b);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      disp_v = (p == 2) ? 8'($urandom) : DisplaySettings[p];
      data_v = (p == 2) ? 8'($urandom) : DataSettings[p];
      program_reg(ledsr_pkg::REG_DISPLAY_MODE, disp_v);
      program_reg(ledsr_pkg::REG_DATA_MODE, data_v);
      sender_gaps   = (p != 3);
      long_hold_req = (p == 1);
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 19))
          0, 1, 2: send_random(ledsr_pkg::ACT_INIT);
          3, 4, 5, 6: send_random(ledsr_pkg::ACT_BRIGHT);
          7, 8, 9, 10, 11, 12, 13: begin
            send_random(ledsr_pkg::ACT_WRITE);
            send_random(ledsr_pkg::ACT_REFRESH);
          end
          default: begin
            // refresh runs of 1 to 20 actions can walk the digit index through its wrap
            repeat ($urandom_range(1, 20)) send_random(ledsr_pkg::ACT_REFRESH);
          end
        endcase
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_slots.size() == 0) begin
      $display("led_driver_serial_refresh regression: pass");
    end else begin
      $display("led_driver_serial_refresh regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/ledsr_pkg.sv
hw/rtl/ledsr_slot_gen.sv
hw/rtl/led_driver_serial_refresh.sv
hw/rtl/ledsr_checker.sv
tb/tb_led_driver_serial_refresh.sv
